[rtl/core/mspm_pkg.sv]
// Shared constants, widths and pointer helpers for the multi-source PCM mixer.
package mspm_pkg;

  localparam int NUM_SOURCES = 8;
  localparam int FIFO_DEPTH  = 9600;
  localparam int FRAME_LEN   = 960;

  localparam int SAMPLE_W = 16;
  localparam int SRC_W    = 3;
  localparam int CFG_W    = 4;
  localparam int PTR_W    = $clog2(FIFO_DEPTH);
  localparam int CNT_W    = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W    = CNT_W + 1;
  localparam int ADDR_W   = $clog2(NUM_SOURCES * FIFO_DEPTH);
  localparam int IDX_W    = $clog2(NUM_SOURCES + 1);
  localparam int FPOS_W   = $clog2(FRAME_LEN);
  localparam int CMP_W    = 8;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  function automatic ptr_t ptr_add(input ptr_t p, input cnt_t n);
    logic [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(n);
    if (s >= SUM_W'(FIFO_DEPTH)) begin
      s = s - SUM_W'(FIFO_DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  function automatic addr_t store_addr(input logic [SRC_W-1:0] s, input ptr_t p);
    return ADDR_W'(s) * ADDR_W'(FIFO_DEPTH) + ADDR_W'(p);
  endfunction

endpackage

[rtl/core/mspm_store.sv]
// Sample store: one write port, one read port with registered read data.
module mspm_store (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  mspm_pkg::addr_t                       wr_addr,
  input  logic signed [mspm_pkg::SAMPLE_W-1:0]  wr_data,
  input  logic                                  rd_en,
  input  mspm_pkg::addr_t                       rd_addr,
  output logic signed [mspm_pkg::SAMPLE_W-1:0]  rd_data
);
  import mspm_pkg::*;

  logic signed [SAMPLE_W-1:0] mem [NUM_SOURCES * FIFO_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/mspm_sat_acc.sv]
// Shared saturating accumulator for the mix sum.
module mspm_sat_acc (
  input  logic                                  clk,
  input  logic                                  clear,
  input  logic                                  add_en,
  input  logic signed [mspm_pkg::SAMPLE_W-1:0]  din,
  output logic signed [mspm_pkg::SAMPLE_W-1:0]  acc
);
  import mspm_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] PCM_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] PCM_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W-1:0] acc_next;

  assign sum = {acc[SAMPLE_W-1], acc} + {din[SAMPLE_W-1], din};

  always_comb begin
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      acc_next = sum[SAMPLE_W] ? PCM_MIN : PCM_MAX;
    end else begin
      acc_next = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (add_en) begin
      acc <= acc_next;
    end
  end

endmodule

[rtl/core/multi_source_pcm_mixer.sv]
// Top level: request sequencer, FIFO pointers, frame counter and output register.
//
//   channel   signals                                        direction
//   request   in_valid, in_stall, req_type, source_index,    in
//             sample
//   result    out_valid, out_stall, mixed_sample,            out
//             frame_last, dropped, ignored
//   config    cfg_valid, cfg_ready, cfg_data                 in
//
// A push goes from S_PUSH through S_WRITE to S_DONE (an ignored push skips
// S_WRITE); a pull steps through the sources in S_PULL, one source head per
// cycle through the single read port of the sample store and the shared adder.
// Reset (rst, synchronous) empties every FIFO, zeroes the frame position and
// active_sources. The store itself is not cleared. A stalled result holds the
// sequencer in its final state; in_stall is high while an item is in work.
module multi_source_pcm_mixer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  req_type,
  input  logic [mspm_pkg::SRC_W-1:0]            source_index,
  input  logic signed [mspm_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mspm_pkg::SAMPLE_W-1:0]  mixed_sample,
  output logic                                  frame_last,
  output logic                                  dropped,
  output logic                                  ignored,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [mspm_pkg::CFG_W-1:0]            cfg_data
);
  import mspm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_PULL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                 state;
  logic [CFG_W-1:0]           active_sources;
  logic                       req;
  logic [SRC_W-1:0]           src;
  logic signed [SAMPLE_W-1:0] smp;
  logic [IDX_W-1:0]           idx;
  logic                       rd_valid;
  ptr_t                       tail;
  logic                       res_drop;
  logic                       res_ign;
  ptr_t                       fifo_head  [NUM_SOURCES];
  cnt_t                       fifo_count [NUM_SOURCES];
  logic [FPOS_W-1:0]          frame_pos;

  logic [CFG_W-1:0]           live;
  logic [SRC_W-1:0]           sel;
  ptr_t                       head_rd;
  cnt_t                       count_rd;
  logic                       push_ign;
  logic                       full;
  logic                       issue;
  logic                       accept;
  logic                       out_free;
  logic                       wr_en;
  addr_t                      wr_addr;
  addr_t                      rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] acc;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  assign live = (active_sources > CFG_W'(NUM_SOURCES)) ? CFG_W'(NUM_SOURCES)
                                                       : active_sources;
  assign sel      = (state == S_PULL) ? idx[SRC_W-1:0] : src;
  assign head_rd  = fifo_head[sel];
  assign count_rd = fifo_count[sel];
  assign push_ign = CMP_W'(src) >= CMP_W'(live);
  assign full     = count_rd >= CNT_W'(FIFO_DEPTH);

  assign issue = (state == S_PULL) && (CMP_W'(idx) < CMP_W'(NUM_SOURCES))
                 && (CMP_W'(idx) < CMP_W'(live)) && (count_rd != '0);

  assign wr_en   = (state == S_WRITE);
  assign wr_addr = store_addr(src, tail);
  assign rd_addr = store_addr(sel, head_rd);

  mspm_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (smp),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mspm_sat_acc u_acc (
    .clk    (clk),
    .clear  (accept),
    .add_en (rd_valid),
    .din    (rd_data),
    .acc    (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      active_sources <= '0;
      src            <= '0;
      idx            <= '0;
      rd_valid       <= 1'b0;
      frame_pos      <= '0;
      out_valid      <= 1'b0;
      res_drop       <= 1'b0;
      res_ign        <= 1'b0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        fifo_head[i]  <= '0;
        fifo_count[i] <= '0;
      end
    end else begin
      rd_valid <= issue;
      if (cfg_valid && cfg_ready) begin
        active_sources <= cfg_data;
      end
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req      <= req_type;
            src      <= source_index;
            smp      <= sample;
            idx      <= '0;
            res_drop <= 1'b0;
            res_ign  <= 1'b0;
            state    <= (req_type == REQ_PULL) ? S_PULL : S_PUSH;
          end
        end
        S_PUSH: begin
          if (push_ign) begin
            res_ign <= 1'b1;
            state   <= S_DONE;
          end else begin
            res_drop <= full;
            if (full) begin
              fifo_head[src] <= ptr_add(head_rd, CNT_W'(1));
              tail           <= head_rd;
            end else begin
              fifo_count[src] <= count_rd + CNT_W'(1);
              tail            <= ptr_add(head_rd, count_rd);
            end
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_DONE;
        end
        S_PULL: begin
          if (issue) begin
            fifo_head[sel]  <= ptr_add(head_rd, CNT_W'(1));
            fifo_count[sel] <= count_rd - CNT_W'(1);
          end
          if (idx == IDX_W'(NUM_SOURCES)) begin
            state <= S_DONE;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            mixed_sample <= (req == REQ_PULL) ? acc : '0;
            frame_last   <= (req == REQ_PULL) && (frame_pos == FPOS_W'(FRAME_LEN - 1));
            dropped      <= (req == REQ_PUSH) && res_drop;
            ignored      <= (req == REQ_PUSH) && res_ign;
            if (req == REQ_PULL) begin
              frame_pos <= (frame_pos == FPOS_W'(FRAME_LEN - 1)) ? '0
                                                                  : frame_pos + FPOS_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the final sequencer state");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count_rd <= CNT_W'(FIFO_DEPTH))
    else $error("FIFO count above depth");

  a_ignored_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && push_ign) |=> !wr_en)
    else $error("ignored push wrote the sample store");

  a_no_write_on_pull: assert property (@(posedge clk) disable iff (rst)
    (state == S_PULL) |-> !wr_en && req == REQ_PULL)
    else $error("store write during pull");

endmodule
